// ===== rtl/cis_pkg.sv =====
// ----------------------------------------------------------------------------
// cis_pkg: shared types and constants of the interlace comb sum core
// Sizes, register indexes and the pipeline control word passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cis_pkg;

  // Default build parameters
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 8;

  // Fixed field and register widths
  localparam int IN_PIX_W  = 8;
  localparam int SIZE_W    = 13;
  localparam int WCMP_W    = SIZE_W + 1;
  localparam int CFG_W     = 64;
  localparam int TOTAL_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Line store organization: one bank per row slot
  localparam int NUM_BANKS = 4;
  localparam int SLOT_W    = 2;

  // Row bookkeeping
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT    = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] LAST_ROW_OFFSET = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] FIRST_OUT_ROW   = SIZE_W'(4);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 2'd0,
    CFG_ACTIVE_HEIGHT = 2'd1,
    CFG_PLANE_START   = 2'd2,
    CFG_WOVEN_START   = 2'd3
  } cfg_index_t;

  // Control word that travels with each pixel through the pipeline
  typedef struct packed {
    logic valid;   // stage holds a pixel
    logic active;  // pixel contributes a comb value
    logic last;    // final pixel of the frame
  } cis_ctrl_t;

endpackage : cis_pkg

`default_nettype wire

// ===== rtl/cis_line_bank.sv =====
// ----------------------------------------------------------------------------
// cis_line_bank: one row slot of the line store
// Holds both planes of one buffered row; read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cis_line_bank #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Read old contents before the write of the same transfer lands
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule : cis_line_bank

`default_nettype wire

// ===== rtl/cis_comb_lane.sv =====
// ----------------------------------------------------------------------------
// cis_comb_lane: five-tap vertical comb value
// Registers |a + 4c + e - 3(b + d)| for one column of five rows.
// ----------------------------------------------------------------------------
`default_nettype none

module cis_comb_lane #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [PIXEL_BITS-1:0]   a,
  input  wire logic [PIXEL_BITS-1:0]   b,
  input  wire logic [PIXEL_BITS-1:0]   c,
  input  wire logic [PIXEL_BITS-1:0]   d,
  input  wire logic [PIXEL_BITS-1:0]   e,
  output logic      [PIXEL_BITS+2:0]   comb
);

  localparam int SW = PIXEL_BITS + 3;

  logic [PIXEL_BITS:0] bd_sum;
  logic [SW-1:0]       pos;
  logic [SW-1:0]       neg;

  // Positive taps and three times the negative taps
  always_comb begin
    bd_sum = (PIXEL_BITS+1)'(b) + (PIXEL_BITS+1)'(d);
    pos    = SW'(a) + SW'(e) + SW'({c, 2'b00});
    neg    = SW'(bd_sum) + SW'({bd_sum, 1'b0});
  end

  // Absolute difference, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      comb <= (pos >= neg) ? (pos - neg) : (neg - pos);
    end
  end

endmodule : cis_comb_lane

`default_nettype wire

// ===== rtl/cis_accum.sv =====
// ----------------------------------------------------------------------------
// cis_accum: merge stage of the comb lanes
// Adds both lane values into 64-bit totals and emits them at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module cis_accum
  import cis_pkg::*;
#(
  parameter int COMB_W = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire cis_ctrl_t            ctrl,
  input  wire logic [COMB_W-1:0]    plane_comb,
  input  wire logic [COMB_W-1:0]    woven_comb,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [2*TOTAL_W-1:0]      m_tdata
);

  logic [TOTAL_W-1:0] plane_sum_start;
  logic [TOTAL_W-1:0] woven_sum_start;
  logic [TOTAL_W-1:0] plane_accum;
  logic [TOTAL_W-1:0] woven_accum;
  logic [TOTAL_W-1:0] plane_accum_next;
  logic [TOTAL_W-1:0] woven_accum_next;
  logic               take;

  assign take = adv && ctrl.valid;

  // Running totals including the pixel in this stage
  always_comb begin
    plane_accum_next = plane_accum;
    woven_accum_next = woven_accum;
    if (ctrl.active) begin
      plane_accum_next = plane_accum + TOTAL_W'(plane_comb);
      woven_accum_next = woven_accum + TOTAL_W'(woven_comb);
    end
  end

  // Start registers and accumulators; a start write reloads its total
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_sum_start <= '0;
      woven_sum_start <= '0;
      plane_accum     <= '0;
      woven_accum     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLANE_START: begin
          plane_sum_start <= cfg_data;
          plane_accum     <= cfg_data;
        end
        CFG_WOVEN_START: begin
          woven_sum_start <= cfg_data;
          woven_accum     <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (ctrl.last) begin
        plane_accum <= plane_sum_start;
        woven_accum <= woven_sum_start;
      end else begin
        plane_accum <= plane_accum_next;
        woven_accum <= woven_accum_next;
      end
    end
  end

  // Output register: load at frame end, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && ctrl.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctrl.last) begin
      m_tdata <= {woven_accum_next, plane_accum_next};
    end
  end

endmodule : cis_accum

`default_nettype wire

// ===== rtl/combe_interlace_sum_core.sv =====
// ----------------------------------------------------------------------------
// combe_interlace_sum_core: five-tap vertical comb sums over interlaced planes
//
// Input stream (s_*): one pixel pair per transfer in raster order, frames of
// active_width columns by active_height + 4 rows (two padding rows on each
// side). Output stream (m_*): one transfer per frame carrying the plane-0 comb
// total and the woven comb total. Configuration goes in through cfg_we,
// cfg_index and cfg_data while the stream is idle.
//
// Throughput: one pixel pair per clock while s_tready is high. Four line store
// banks, one per row slot, are all read once per pixel and the bank of the
// current row slot is written; two comb lanes and the accumulators advance
// whenever the pipeline is not stalled. The frame result passes the line store
// read, comb lanes and output register after the frame's last pixel is taken.
// Stall: s_tready drops only when a finished frame result is still waiting
// and the next frame end has reached the merge stage; otherwise pixels keep
// flowing while the result waits for m_tready.
// Reset: counters clear, sizes return to 1x1, start values and totals to zero.
// Line store contents are not cleared; the padding rows fill them.
// ----------------------------------------------------------------------------
`default_nettype none

module combe_interlace_sum_core
  import cis_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Fields from bit 0: plane0_pixel[7:0], plane1_pixel[15:8]
  input  wire logic [2*IN_PIX_W-1:0] s_tdata,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // Fields from bit 0: plane_comb_total[63:0], woven_comb_total[127:64]
  output logic [2*TOTAL_W-1:0]      m_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int PW     = PIXEL_BITS;
  localparam int COMB_W = PIXEL_BITS + 3;

  // Size registers and position counters
  logic [SIZE_W-1:0] active_width;
  logic [SIZE_W-1:0] active_height;
  logic [XW-1:0]     column_count;
  logic [SIZE_W-1:0] row_count;

  logic [WCMP_W-1:0] eff_width;
  logic [SIZE_W-1:0] eff_height;
  logic [SIZE_W-1:0] last_row;
  logic              col_end;
  logic              row_end;

  logic              adv;
  logic              accept;
  logic [PW-1:0]     in_p0;
  logic [PW-1:0]     in_p1;

  // Stage 1: line store read
  cis_ctrl_t         s1_ctrl;
  logic              s1_odd;
  logic [SLOT_W-1:0] s1_rslot;
  logic [PW-1:0]     s1_e0;
  logic [PW-1:0]     s1_e1;
  logic [2*PW-1:0]   bank_rd [NUM_BANKS];
  logic [PW-1:0]     tap0 [NUM_BANKS];
  logic [PW-1:0]     tap1 [NUM_BANKS];
  logic [SLOT_W-1:0] tap_sel;

  // Stage 2: comb lanes
  cis_ctrl_t         s2_ctrl;
  logic [PW-1:0]     wa, wb, wc, wd, we_pix;
  logic [COMB_W-1:0] plane_comb;
  logic [COMB_W-1:0] woven_comb;

  // Hold everything when a frame end meets an untaken result
  assign adv      = !(s2_ctrl.valid && s2_ctrl.last && m_tvalid && !m_tready);
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  assign in_p0 = PW'(s_tdata[IN_PIX_W-1:0]);
  assign in_p1 = PW'(s_tdata[2*IN_PIX_W-1:IN_PIX_W]);

  // Clamp sizes and find the ends of row and frame
  always_comb begin
    eff_width = WCMP_W'(active_width);
    if (active_width == '0) begin
      eff_width = WCMP_W'(1);
    end else if (eff_width > WCMP_W'(MAX_WIDTH)) begin
      eff_width = WCMP_W'(MAX_WIDTH);
    end
    eff_height = active_height;
    if (active_height == '0) begin
      eff_height = SIZE_W'(1);
    end else if (active_height > HEIGHT_LIMIT) begin
      eff_height = HEIGHT_LIMIT;
    end
    last_row = eff_height + LAST_ROW_OFFSET;
    col_end  = (WCMP_W'(column_count) + WCMP_W'(1)) >= eff_width;
    row_end  = row_count >= last_row;
  end

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= SIZE_W'(1);
      active_height <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[SIZE_W-1:0];
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance column and row on every pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + SIZE_W'(1);
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  // Line store banks, one per row slot, both planes side by side
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    cis_line_bank #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PW)
    ) u_bank (
      .clk   (clk),
      .re    (accept),
      .we    (accept && (row_count[SLOT_W-1:0] == SLOT_W'(k))),
      .addr  (column_count),
      .wdata ({in_p1, in_p0}),
      .rdata (bank_rd[k])
    );
  end

  // Stage 1 control and current pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (adv) begin
      s1_ctrl.valid  <= s_tvalid;
      s1_ctrl.active <= row_count >= FIRST_OUT_ROW;
      s1_ctrl.last   <= col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_odd   <= row_count[0];
      s1_rslot <= row_count[SLOT_W-1:0];
      s1_e0    <= in_p0;
      s1_e1    <= in_p1;
    end
  end

  // Order the banks oldest row first
  always_comb begin
    tap_sel = '0;
    for (int k = 0; k < NUM_BANKS; k++) begin
      tap_sel = s1_rslot + SLOT_W'(k);
      tap0[k] = bank_rd[tap_sel][PW-1:0];
      tap1[k] = bank_rd[tap_sel][2*PW-1:PW];
    end
  end

  // Weave: odd centre rows take the outer and centre rows from plane 0, the rows beside the centre from plane 1
  always_comb begin
    if (s1_odd) begin
      wa = tap0[0]; wb = tap1[1]; wc = tap0[2]; wd = tap1[3]; we_pix = s1_e0;
    end else begin
      wa = tap1[0]; wb = tap0[1]; wc = tap1[2]; wd = tap0[3]; we_pix = s1_e1;
    end
  end

  cis_comb_lane #(.PIXEL_BITS(PIXEL_BITS)) u_plane_lane (
    .clk  (clk),
    .en   (adv),
    .a    (tap0[0]),
    .b    (tap0[1]),
    .c    (tap0[2]),
    .d    (tap0[3]),
    .e    (s1_e0),
    .comb (plane_comb)
  );

  cis_comb_lane #(.PIXEL_BITS(PIXEL_BITS)) u_woven_lane (
    .clk  (clk),
    .en   (adv),
    .a    (wa),
    .b    (wb),
    .c    (wc),
    .d    (wd),
    .e    (we_pix),
    .comb (woven_comb)
  );

  // Stage 2 control follows the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (adv) begin
      s2_ctrl <= s1_ctrl;
    end
  end

  // Merge stage: totals and frame result
  cis_accum #(.COMB_W(COMB_W)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctrl       (s2_ctrl),
    .plane_comb (plane_comb),
    .woven_comb (woven_comb),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // A new result appears only after a frame end left the lanes
  a_result_from_frame_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s2_ctrl.valid && s2_ctrl.last))
    else $error("result raised without a frame end in the merge stage");

  // A stalled stage-1 pixel keeps its row slot
  a_stall_holds_stage1: assert property (@(posedge clk) disable iff (rst)
    (s1_ctrl.valid && !adv) |=> (s1_ctrl.valid && $stable(s1_rslot)))
    else $error("stage-1 pixel lost during stall");

  // Reset empties the pipeline and the output register
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!s1_ctrl.valid && !s2_ctrl.valid && !m_tvalid))
    else $error("pipeline not empty after reset");

endmodule : combe_interlace_sum_core

`default_nettype wire

// ===== test/combe_interlace_sum_core_tb.sv =====
// ----------------------------------------------------------------------------
// combe_interlace_sum_core_tb: self-checking bench for the comb sum core
// Streams pixel pairs in raster order and checks every frame result against
// a cycle-free predictor of both comb sums. A short table covers padding
// rows, pixel extremes, size clamping and start value wrap, then random
// phases vary sizes, start values, idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module combe_interlace_sum_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cis_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_index_t   idx;
    logic [63:0]  value;
    logic [7:0]   p0;
    logic [7:0]   p1;
    logic         typed;
    logic [127:0] totals;   // {woven, plane}
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [15:0]        s_tdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [127:0]       m_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_index_t         cfg_index = CFG_ACTIVE_WIDTH;
  logic [63:0]        cfg_data = '0;

  bit                 bursts_on = 1'b1;
  bit                 hold_req = 1'b0;
  int                 errors = 0;
  logic [127:0]       frame_totals_q[$];
  dir_row_t           dir_rows[$];

  // Predictor state: line stores, counters, registers, accumulators
  logic [7:0]         p0_lines [0:4*MAX_W-1];
  logic [7:0]         p1_lines [0:4*MAX_W-1];
  int unsigned        col_q = 0;
  int unsigned        row_q = 0;
  logic [12:0]        width_reg = 13'd1;
  logic [12:0]        height_reg = 13'd1;
  logic [63:0]        plane_start = '0;
  logic [63:0]        woven_start = '0;
  logic [63:0]        plane_acc = '0;
  logic [63:0]        woven_acc = '0;

  combe_interlace_sum_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),    // plane0_pixel[7:0], plane1_pixel[15:8]
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),    // plane_comb_total[63:0], woven_comb_total[127:64]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Five-tap comb magnitude |a + 4c + e - 3(b + d)|
  function automatic logic [63:0] comb_mag(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d,
                                           input logic [7:0] e);
    int t;
    t = int'(a) + 4 * int'(c) + int'(e) - 3 * (int'(b) + int'(d));
    return (t < 0) ? 64'(-t) : 64'(t);
  endfunction

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_LIMIT) return 32'(HEIGHT_LIMIT);
    return 32'(height_reg);
  endfunction

  // Advance the predictor by one pixel pair; return 1 with the frame totals
  function automatic bit comb_sum_step(input logic [7:0] p0, input logic [7:0] p1,
                                       output logic [127:0] totals);
    int unsigned s0, s1, s2, s3;
    bit done;
    done = 1'b0;
    totals = '0;
    // slots of rows r-4 .. r-1 at this column
    s0 = (row_q & 3) * MAX_W + col_q;
    s1 = ((row_q + 1) & 3) * MAX_W + col_q;
    s2 = ((row_q + 2) & 3) * MAX_W + col_q;
    s3 = ((row_q + 3) & 3) * MAX_W + col_q;
    if (row_q >= 4) begin
      plane_acc += comb_mag(p0_lines[s0], p0_lines[s1], p0_lines[s2], p0_lines[s3], p0);
      if (row_q & 1)
        woven_acc += comb_mag(p0_lines[s0], p1_lines[s1], p0_lines[s2], p1_lines[s3], p0);
      else
        woven_acc += comb_mag(p1_lines[s0], p0_lines[s1], p1_lines[s2], p0_lines[s3], p1);
    end
    p0_lines[s0] = p0;
    p1_lines[s0] = p1;
    // wrap counters; a counter past a shrunken end wraps at once
    if (col_q + 1 >= used_width()) begin
      col_q = 0;
      if (row_q >= used_height() + 3) begin
        row_q = 0;
        totals = {woven_acc, plane_acc};
        plane_acc = plane_start;
        woven_acc = woven_start;
        done = 1'b1;
      end else begin
        row_q = row_q + 1;
      end
    end else begin
      col_q = col_q + 1;
    end
    return done;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_start();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic dir_row_t cfg_row(cfg_index_t idx, logic [63:0] value);
    return '{ROW_CFG, idx, value, 8'd0, 8'd0, 1'b0, 128'd0};
  endfunction

  function automatic dir_row_t pix_row(logic [7:0] p0, logic [7:0] p1);
    return '{ROW_PIX, CFG_ACTIVE_WIDTH, 64'd0, p0, p1, 1'b0, 128'd0};
  endfunction

  function automatic dir_row_t pix_check_row(logic [7:0] p0, logic [7:0] p1,
                                             logic [63:0] plane, logic [63:0] woven);
    return '{ROW_PIX, CFG_ACTIVE_WIDTH, 64'd0, p0, p1, 1'b1, {woven, plane}};
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Offer one pixel pair, wait for its transfer, record the expected totals
  task automatic drive_pair(input logic [7:0] p0, input logic [7:0] p1,
                            input logic typed, input logic [127:0] typed_totals);
    logic [127:0] totals;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p1, p0};
    do @(posedge clk); while (!s_tready);
    if (comb_sum_step(p0, p1, totals))
      frame_totals_q = {frame_totals_q, (typed ? typed_totals : totals)};
  endtask

  // Stop offering, wait for all frame results and let the pipeline empty
  task automatic drain_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frame_totals_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE_WIDTH:  width_reg = value[12:0];
      CFG_ACTIVE_HEIGHT: height_reg = value[12:0];
      CFG_PLANE_START: begin
        plane_start = value;
        plane_acc   = value;
      end
      CFG_WOVEN_START: begin
        woven_start = value;
        woven_acc   = value;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expected totals
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_totals_q.size() == 0) begin
        $display("%0t: unexpected frame result: plane %h woven %h",
                 $time, m_tdata[63:0], m_tdata[127:64]);
        errors++;
      end else begin
        want = frame_totals_q.pop_front();
        if (m_tdata[63:0] !== want[63:0]) begin
          $display("%0t: plane total expected %h, actual %h",
                   $time, want[63:0], m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[127:64] !== want[127:64]) begin
          $display("%0t: woven total expected %h, actual %h",
                   $time, want[127:64], m_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int          n;
    int          pairs_sent;
    int unsigned new_w;

    pairs_sent = 0;

    // Directed frames: 1x1 output area, five stream rows per frame
    add_row(cfg_row(CFG_ACTIVE_WIDTH, 64'd0));    // zero width counts as one
    add_row(cfg_row(CFG_ACTIVE_HEIGHT, 64'd0));   // zero height counts as one
    // plane rows high-low-high-low-high: padding rows only fill the stores
    add_row(pix_row(8'hFF, 8'h00));
    add_row(pix_row(8'h00, 8'h00));
    add_row(pix_row(8'hFF, 8'h00));
    add_row(pix_row(8'h00, 8'h00));
    add_row(pix_check_row(8'hFF, 8'h00, 64'd1530, 64'd0));
    // inverted pattern: negative comb, woven lanes take plane 0 on b and d
    add_row(pix_row(8'h00, 8'h00));
    add_row(pix_row(8'hFF, 8'h00));
    add_row(pix_row(8'h00, 8'h00));
    add_row(pix_row(8'hFF, 8'h00));
    add_row(pix_check_row(8'h00, 8'h00, 64'd1530, 64'd1530));
    // start values near the top: the plane sum wraps past 2^64
    add_row(cfg_row(CFG_PLANE_START, '1));
    add_row(cfg_row(CFG_WOVEN_START, 64'h8000_0000_0000_0000));
    add_row(pix_row(8'hFF, 8'hFF));
    add_row(pix_row(8'h00, 8'hFF));
    add_row(pix_row(8'hFF, 8'hFF));
    add_row(pix_row(8'h00, 8'hFF));
    add_row(pix_check_row(8'hFF, 8'hFF, 64'd1529, 64'h8000_0000_0000_05FA));
    // two output rows: even and odd centre rows swap the woven planes
    add_row(cfg_row(CFG_ACTIVE_HEIGHT, 64'd2));
    add_row(pix_row(8'd17, 8'd200));
    add_row(pix_row(8'd99, 8'd3));
    add_row(pix_row(8'd250, 8'd128));
    add_row(pix_row(8'd1, 8'd77));
    add_row(pix_row(8'd64, 8'd255));
    add_row(pix_row(8'd0, 8'd32));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_stream();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        drive_pair(dir_rows[i].p0, dir_rows[i].p1, dir_rows[i].typed, dir_rows[i].totals);
      end
    end

    // Back-pressure: tiny frames while the receiver holds off for a long stretch
    drain_stream();
    write_reg(CFG_ACTIVE_WIDTH, 64'd2);
    write_reg(CFG_ACTIVE_HEIGHT, 64'd1);
    bursts_on = 1'b0;
    hold_req  = 1'b1;
    repeat (80) drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);

    // Random phases; phases may end mid-frame
    while (pairs_sent < 350) begin
      drain_stream();
      if ($urandom_range(0, 3) != 0) begin
        // grow the width only at a frame boundary: wider rows would read
        // line store columns that were never written
        if (col_q == 0 && row_q == 0)
          new_w = $urandom_range(0, 8);
        else
          new_w = $urandom_range(1, used_width());
        write_reg(CFG_ACTIVE_WIDTH, 64'(new_w));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_ACTIVE_HEIGHT, 64'($urandom_range(0, 4)));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_PLANE_START, rand_start());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_WOVEN_START, rand_start());
      bursts_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(20, 80);
      repeat (n) begin
        drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);
        pairs_sent++;
      end
    end

    // Close the open frame so the width may grow
    bursts_on = 1'b1;
    while (col_q != 0 || row_q != 0)
      drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);

    // Oversize width: part of a wide first row, then shrink to close the frame
    drain_stream();
    write_reg(CFG_ACTIVE_WIDTH, 64'h1FFF);
    write_reg(CFG_ACTIVE_HEIGHT, 64'd0);
    write_reg(CFG_PLANE_START, {$urandom, $urandom});
    write_reg(CFG_WOVEN_START, '1);
    repeat (40) drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);
    drain_stream();
    write_reg(CFG_ACTIVE_WIDTH, 64'd1);
    while (col_q != 0 || row_q != 0)
      drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);

    // Oversize height: many rows, then a shrunken end wraps the row counter
    drain_stream();
    write_reg(CFG_ACTIVE_WIDTH, 64'd0);
    write_reg(CFG_ACTIVE_HEIGHT, 64'h1FFF);
    repeat (40) drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);
    drain_stream();
    write_reg(CFG_ACTIVE_HEIGHT, 64'd2);
    while (col_q != 0 || row_q != 0)
      drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);

    // Closing stretch without idling on either side
    drain_stream();
    write_reg(CFG_ACTIVE_WIDTH, 64'd5);
    write_reg(CFG_ACTIVE_HEIGHT, 64'd2);
    write_reg(CFG_PLANE_START, '0);
    write_reg(CFG_WOVEN_START, '0);
    bursts_on = 1'b0;
    repeat (90) drive_pair(rand_pixel(), rand_pixel(), 1'b0, '0);

    drain_stream();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
